/* sv/ookpwd_pkg.sv */
// Shared types and constants of the pulse-width remote code decoder.
package ookpwd_pkg;

    localparam int DUR_W       = 16;
    localparam int CODE_W      = 32;
    localparam int BITS_W      = 6;
    localparam int CNT_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 26;
    localparam int COUNT_W     = 3;
    localparam int CFG_SLOTS   = 4;

    localparam logic [BITS_W-1:0]     MAX_BITS    = 6'd32;
    localparam logic [BITS_W-1:0]     MIN_BITS    = 6'd16;
    localparam logic [CNT_W-1:0]      MIN_PULSES  = 5'd20;
    localparam logic [CFG_DATA_W-1:0] SLOT0_RESET = 26'd12864862;
    localparam logic [COUNT_W-1:0]    COUNT_RESET = 3'd1;

    typedef enum logic [1:0] {
        PH_SKIP_HIGH,
        PH_SKIP_LOW,
        PH_PAIR,
        PH_DONE
    } t_phase;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLOT0,
        REG_SLOT1,
        REG_SLOT2,
        REG_SLOT3,
        REG_COUNT
    } t_cfg_reg;

    // Packed protocol word, most significant field first.
    typedef struct packed {
        logic [3:0] zero_low;
        logic [3:0] zero_high;
        logic [3:0] one_low;
        logic [3:0] one_high;
        logic [9:0] unit;
    } t_proto;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             last;
    } t_pulse;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits;
    } t_slot_res;

    typedef struct packed {
        logic              code_valid;
        logic [CODE_W-1:0] decoded_code;
        logic [1:0]        protocol_slot;
        logic [BITS_W-1:0] bit_count;
    } t_result;

endpackage

/* sv/ookpwd_ifs.sv */
// Handshake channels of the decoder: pulse input, code output, configuration writes.
interface ookpwd_pulse_if import ookpwd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             pulse_level;
    logic [DUR_W-1:0] pulse_duration;
    logic             last_pulse;

    modport source (output valid, pulse_level, pulse_duration, last_pulse, input ready);
    modport sink   (input valid, pulse_level, pulse_duration, last_pulse, output ready);
endinterface

interface ookpwd_code_if import ookpwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              code_valid;
    logic [CODE_W-1:0] decoded_code;
    logic [1:0]        protocol_slot;
    logic [BITS_W-1:0] bit_count;

    modport source (output valid, code_valid, decoded_code, protocol_slot, bit_count,
                    input ready);
    modport sink   (input valid, code_valid, decoded_code, protocol_slot, bit_count,
                    output ready);
endinterface

interface ookpwd_cfg_if import ookpwd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ookpwd_slot.sv */
// One protocol slot: skip leading pulses, pair high/low times, shift in bits.
module ookpwd_slot import ookpwd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_pulse    i_pulse,
    input  t_proto    i_proto,
    output t_slot_res o_next
);

    t_phase            r_phase, n_phase;
    logic [DUR_W-1:0]  r_pending, n_pending;
    logic              r_has, n_has;
    logic [CODE_W-1:0] r_code, n_code;
    logic [BITS_W-1:0] r_bits, n_bits;

    logic go_pair;
    logic hit_one;
    logic hit_zero;

    // Within 1.5 units: 2*|t - f*unit| < 3*unit.
    function automatic logic near(input logic [DUR_W-1:0] t, input logic [3:0] f,
                                  input logic [9:0] unit);
        logic [13:0]      expect_t;
        logic [DUR_W-1:0] diff;
        logic [11:0]      lim;
        expect_t = f * unit;
        diff     = (t > {2'b00, expect_t}) ? t - {2'b00, expect_t} : {2'b00, expect_t} - t;
        lim      = {2'b00, unit} + {1'b0, unit, 1'b0};
        return {diff, 1'b0} < {5'd0, lim};
    endfunction

    assign hit_one  = near(r_pending, i_proto.one_high, i_proto.unit)
                    & near(i_pulse.duration, i_proto.one_low, i_proto.unit);
    assign hit_zero = near(r_pending, i_proto.zero_high, i_proto.unit)
                    & near(i_pulse.duration, i_proto.zero_low, i_proto.unit);

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_has     = r_has;
        n_code    = r_code;
        n_bits    = r_bits;
        go_pair   = 1'b0;
        case (r_phase)
            PH_SKIP_HIGH: begin
                if (i_pulse.level && !i_pulse.last) begin
                    n_phase = PH_SKIP_HIGH;
                end else if (!i_pulse.level && !i_pulse.last) begin
                    n_phase = PH_SKIP_LOW;
                end else begin
                    n_phase = PH_PAIR;
                    go_pair = 1'b1;
                end
            end
            PH_SKIP_LOW: begin
                if (!(!i_pulse.level && !i_pulse.last)) begin
                    n_phase = PH_PAIR;
                    go_pair = 1'b1;
                end
            end
            PH_PAIR: go_pair = 1'b1;
            default: go_pair = 1'b0;
        endcase
        if (go_pair) begin
            if (r_has) begin
                n_has = 1'b0;
                if (hit_one || hit_zero) begin
                    n_code = {r_code[CODE_W-2:0], hit_one};
                    n_bits = r_bits + 6'd1;
                    if (n_bits >= MAX_BITS) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end else if (!i_pulse.last) begin
                n_pending = i_pulse.duration;
                n_has     = 1'b1;
            end
        end
    end

    assign o_next.code = n_code;
    assign o_next.bits = n_bits;

    // Drop all capture state after the final pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_pulse.last)) begin
            r_phase   <= PH_SKIP_HIGH;
            r_pending <= '0;
            r_has     <= 1'b0;
            r_code    <= '0;
            r_bits    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_has     <= n_has;
            r_code    <= n_code;
            r_bits    <= n_bits;
        end
    end

endmodule

/* sv/ookpwd_select.sv */
// Pick the lowest slot in use that decoded enough bits, if the capture had enough pulses.
module ookpwd_select import ookpwd_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  t_slot_res          i_res [SLOT_COUNT],
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_pulses_ok,
    output t_result            o_result
);

    always_comb begin
        logic found;
        found    = 1'b0;
        o_result = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!found && i_pulses_ok && (4'(s) < {1'b0, i_count})
                && (i_res[s].bits >= MIN_BITS)) begin
                found                  = 1'b1;
                o_result.code_valid    = 1'b1;
                o_result.decoded_code  = i_res[s].code;
                o_result.protocol_slot = 2'(s);
                o_result.bit_count     = i_res[s].bits;
            end
        end
    end

endmodule

/* sv/ook_pulse_width_decoder.sv */
// Top level of the on-off-keyed pulse-width remote code decoder.
//
// Use: captured pulses enter on i_pulse as (pulse_level, pulse_duration,
// last_pulse), one transfer per pulse. Every protocol slot decodes the same
// stream in parallel. The transfer that carries last_pulse closes the capture
// and produces exactly one transfer on o_code; other pulses produce none.
// Protocol words and the slot count are written through i_cfg (index 0..3
// are the slot protocols, index 4 the count); other indexes are ignored.
// Write configuration only while no capture is in flight.
// Throughput: one pulse per clock while no last pulse waits on a stalled
// o_code. Path: input register, then result register; the per-slot
// compare and the slot pick sit between the two.
// Reset: protocol registers return to their defaults, every slot to the
// skip-high phase, the pulse counter to zero. If o_code stalls, the result
// register holds; pulses keep flowing until a second last pulse reaches the
// input register, which then waits and backs up i_pulse.ready.
module ook_pulse_width_decoder import ookpwd_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ookpwd_pulse_if.sink  i_pulse,
    ookpwd_cfg_if.sink    i_cfg,
    ookpwd_code_if.source o_code
);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_proto [CFG_SLOTS];
    logic [COUNT_W-1:0]    r_count;

    // Input register stage.
    logic   r_s1_valid;
    t_pulse r_s1;
    logic   s1_go;
    logic   in_xfer;

    // Pulse counter, saturating at the minimum capture length.
    logic [CNT_W-1:0] r_pulse_cnt, n_pulse_cnt;

    // Result register stage.
    logic    r_out_valid;
    t_result r_out;
    t_result sel_result;

    t_slot_res slot_next [SLOT_COUNT];

    // Configuration is always taken; the user must write it only while idle, the block does not enforce this.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto[0] <= SLOT0_RESET;
            for (int k = 1; k < CFG_SLOTS; k++) begin
                r_proto[k] <= '0;
            end
            r_count <= COUNT_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_SLOT0: r_proto[0] <= i_cfg.data;
                REG_SLOT1: r_proto[1] <= i_cfg.data;
                REG_SLOT2: r_proto[2] <= i_cfg.data;
                REG_SLOT3: r_proto[3] <= i_cfg.data;
                REG_COUNT: r_count    <= i_cfg.data[COUNT_W-1:0];
                default:   r_count    <= r_count;
            endcase
        end
    end

    // Advance the input stage unless it holds a last pulse that has nowhere to go.
    assign s1_go         = r_s1_valid && (!r_s1.last || !r_out_valid || o_code.ready);
    assign i_pulse.ready = !r_s1_valid || s1_go;
    assign in_xfer       = i_pulse.valid && i_pulse.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pulse.ready) begin
            r_s1_valid <= i_pulse.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.level    <= i_pulse.pulse_level;
            r_s1.duration <= i_pulse.pulse_duration;
            r_s1.last     <= i_pulse.last_pulse;
        end
    end

    assign n_pulse_cnt = (r_pulse_cnt < MIN_PULSES) ? r_pulse_cnt + 5'd1 : r_pulse_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_cnt <= '0;
        end else if (s1_go) begin
            r_pulse_cnt <= r_s1.last ? '0 : n_pulse_cnt;
        end
    end

    // One decoder per slot; slots without a register see an all-zero protocol.
    for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
        t_proto slot_proto;
        if (s < CFG_SLOTS) begin : g_cfg
            assign slot_proto = t_proto'(r_proto[s]);
        end else begin : g_zero
            assign slot_proto = '0;
        end
        ookpwd_slot u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (s1_go),
            .i_pulse (r_s1),
            .i_proto (slot_proto),
            .o_next  (slot_next[s])
        );
    end

    ookpwd_select #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_select (
        .i_res       (slot_next),
        .i_count     (r_count),
        .i_pulses_ok (n_pulse_cnt >= MIN_PULSES),
        .o_result    (sel_result)
    );

    // Load the result register on a closing pulse; drop it once transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.last) begin
            r_out <= sel_result;
        end
    end

    assign o_code.valid         = r_out_valid;
    assign o_code.code_valid    = r_out.code_valid;
    assign o_code.decoded_code  = r_out.decoded_code;
    assign o_code.protocol_slot = r_out.protocol_slot;
    assign o_code.bit_count     = r_out.bit_count;

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && r_s1.last))
        else $error("result appeared without a closing pulse");

    a_plain_pulse_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.last) |-> i_pulse.ready)
        else $error("input stalled behind a pulse that makes no result");

    a_counter_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1.last) |=> (r_pulse_cnt == '0))
        else $error("pulse counter not cleared after a capture");

    a_valid_code_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.code_valid) |->
            (r_out.bit_count >= MIN_BITS && r_out.bit_count <= MAX_BITS))
        else $error("reported code has a bit count out of range");

endmodule

/* tb/ook_pulse_width_decoder_test.sv */
// Self-checking test of the pulse-width remote code decoder: random pulse captures, bit-exact prediction.
`timescale 1ns / 1ps

module ook_pulse_width_decoder_test;
    import ookpwd_pkg::*;

    localparam int SLOT_COUNT   = 4;
    localparam int DRAIN_CYCLES = 8;        // idle wait after every code is back
    localparam int LONG_HOLD    = 300;      // receiver back-pressure stretch, in cycles
    localparam int TIMEOUT_NS   = 5_000_000;

    // Indexes outside the register map: the block must drop these writes.
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_A = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_B = 3'd7;

    localparam t_result NO_CODE = '0;

    // One row of the directed table: a pulse, how often to repeat it, and
    // whether the capture it closes must come back as the empty result.
    typedef struct packed {
        logic        level;
        logic [15:0] duration;
        logic        last;
        logic [4:0]  reps;
        logic        no_code;
    } t_row;

    // Directed captures under the reset protocol (unit 350, one = 3/1, zero = 1/3).
    localparam t_row DIRECTED [8] = '{
        // four pulses: leading high, low sync, then a one whose low closes
        // the capture; too short to report anything
        '{1'b1, 16'hFFFF, 1'b0, 5'd1,  1'b0},
        '{1'b0, 16'h0000, 1'b0, 5'd1,  1'b0},
        '{1'b1, 16'd1050, 1'b0, 5'd1,  1'b0},
        '{1'b0, 16'd350,  1'b1, 5'd1,  1'b1},
        // a lone final high: cannot start a pair
        '{1'b1, 16'hFFFF, 1'b1, 5'd1,  1'b1},
        // a lone final low at zero width
        '{1'b0, 16'h0000, 1'b1, 5'd1,  1'b1},
        // exactly twenty pulses, nineteen leading highs skipped and a final
        // low: count is met but no bits were decoded
        '{1'b1, 16'hFFFF, 1'b0, 5'd19, 1'b0},
        '{1'b0, 16'h0000, 1'b1, 5'd1,  1'b1}
    };

    typedef enum {RX_OPEN, RX_SPARSE, RX_PATTERN, RX_COIN} t_rx_mode;

    typedef struct {
        t_pulse  p;
        bit      no_code;
    } t_item;

    logic i_clk;
    logic i_rst_n;

    ookpwd_pulse_if pulse_ch ();
    ookpwd_code_if  code_ch ();
    ookpwd_cfg_if   cfg_ch ();

    ook_pulse_width_decoder #(.SLOT_COUNT(SLOT_COUNT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (pulse_ch),
        .i_cfg   (cfg_ch),
        .o_code  (code_ch)
    );

    // Configuration as the decoder should hold it.
    t_proto      proto_reg [CFG_SLOTS];
    logic [2:0]  slots_used_reg;

    // Per-slot decode progress through the current capture.
    int unsigned pulses_seen;
    t_phase      track_phase   [SLOT_COUNT];
    logic [15:0] track_high    [SLOT_COUNT];
    bit          track_holding [SLOT_COUNT];
    logic [31:0] track_code    [SLOT_COUNT];
    logic [5:0]  track_bits    [SLOT_COUNT];

    t_item       pulse_backlog [$];
    t_result     expected_codes [$];
    int          phase_items;
    int          error_count;

    // Sender and receiver pacing.
    t_item       on_wire;
    t_result     outcome;
    int          burst_left;
    int          gap_left;
    bit          sender_hold;
    bit          long_hold_req;
    int          hold_left;
    int          mode_left;
    t_rx_mode    rx_mode;
    logic [7:0]  rx_pattern;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_capture();
        pulses_seen = 0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            track_phase[s]   = PH_SKIP_HIGH;
            track_high[s]    = '0;
            track_holding[s] = 1'b0;
            track_code[s]    = '0;
            track_bits[s]    = '0;
        end
    endfunction

    // True when t lies strictly within one and a half units of factor * unit.
    // Kept in integers: doubling both sides removes the half.
    function automatic bit within_span(input logic [15:0] t, input logic [3:0] factor,
                                       input logic [9:0] unit);
        int unsigned center;
        int unsigned gap;
        center = factor * unit;
        gap = (t > center) ? t - center : center - t;
        return 2 * gap < 3 * unit;
    endfunction

    // Advance every slot by one pulse. Returns 1 when the pulse closes the
    // capture, with the code the decoder must report in res.
    function automatic bit decode_pulse(input t_pulse pl, output t_result res);
        int unsigned used;
        t_proto      pr;
        res = NO_CODE;
        used = (slots_used_reg > SLOT_COUNT) ? SLOT_COUNT : slots_used_reg;
        if (pulses_seen < MIN_PULSES)
            pulses_seen++;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            // slots past the register file run with an all-zero protocol
            pr = (s < CFG_SLOTS) ? proto_reg[s] : '0;
            // skip leading highs, then the sync lows; the final pulse is
            // never swallowed by either
            if (track_phase[s] == PH_SKIP_HIGH) begin
                if (pl.level && !pl.last)
                    continue;
                track_phase[s] = PH_SKIP_LOW;
            end
            if (track_phase[s] == PH_SKIP_LOW) begin
                if (!pl.level && !pl.last)
                    continue;
                track_phase[s] = PH_PAIR;
            end
            if (track_phase[s] != PH_PAIR)
                continue;
            // pairs are taken by position, not by level
            if (!track_holding[s]) begin
                if (!pl.last) begin
                    track_high[s]    = pl.duration;
                    track_holding[s] = 1'b1;
                end
                continue;
            end
            track_holding[s] = 1'b0;
            // the one pattern wins when both patterns fit
            if (within_span(track_high[s], pr.one_high, pr.unit) &&
                within_span(pl.duration, pr.one_low, pr.unit)) begin
                track_code[s] = {track_code[s][30:0], 1'b1};
            end else if (within_span(track_high[s], pr.zero_high, pr.unit) &&
                         within_span(pl.duration, pr.zero_low, pr.unit)) begin
                track_code[s] = {track_code[s][30:0], 1'b0};
            end else begin
                track_phase[s] = PH_DONE;
                continue;
            end
            track_bits[s]++;
            if (track_bits[s] >= MAX_BITS)
                track_phase[s] = PH_DONE;
        end
        if (!pl.last)
            return 1'b0;
        // report the lowest slot in use with enough bits, and only for a
        // capture of at least the minimum pulse count
        if (pulses_seen >= MIN_PULSES) begin
            for (int s = 0; s < used; s++) begin
                if (track_bits[s] >= MIN_BITS) begin
                    res = {1'b1, track_code[s], 2'(s), track_bits[s]};
                    break;
                end
            end
        end
        clear_capture();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic void enqueue(input logic lvl, input logic [15:0] dur,
                                    input logic fin, input bit no_code);
        t_item it;
        it.p.level    = lvl;
        it.p.duration = dur;
        it.p.last     = fin;
        it.no_code    = no_code;
        pulse_backlog.push_back(it);
        phase_items++;
    endfunction

    // A width near factor * unit: inside the tolerance when fits is set,
    // just outside it otherwise. Tolerance edges are hit on purpose.
    function automatic logic [15:0] near_width(input logic [3:0] factor, input logic [9:0] unit,
                                               input bit fits);
        int center;
        int span;
        int d;
        int v;
        if (unit == 0)
            return 16'($urandom);
        center = factor * unit;
        if (fits) begin
            span = (3 * unit - 1) / 2;
            if ($urandom_range(0, 7) == 0)
                d = $urandom_range(0, 1) ? span : -span;
            else
                d = int'($urandom_range(0, 2 * span)) - span;
        end else begin
            span = (3 * unit + 1) / 2 + int'($urandom_range(0, 3));
            d = $urandom_range(0, 1) ? span : -span;
        end
        v = center + d;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // One capture. Well-formed ones follow a slot's protocol with jitter and
    // the odd broken pair; the rest is random pulse noise.
    function automatic void queue_capture(input bit well_formed);
        int unsigned n_pulses;
        int unsigned n_lead;
        int unsigned n_sync;
        int unsigned n_bits;
        int unsigned tail;
        t_proto      pr;
        bit          one;
        bit          clean;
        if (!well_formed) begin
            n_pulses = $urandom_range(1, 30);
            for (int i = 0; i < n_pulses; i++)
                enqueue(1'($urandom), 16'($urandom), i == n_pulses - 1, 1'b0);
            return;
        end
        pr = proto_reg[2'($urandom_range(0, CFG_SLOTS - 1))];
        n_lead = $urandom_range(0, 2);
        n_sync = $urandom_range(1, 2);
        n_bits = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : $urandom_range(16, 34);
        // tail 0: the final low closes a pending pair; 1: an extra final
        // high; 2: an extra final low after a complete pair
        tail = $urandom_range(0, 2);
        for (int i = 0; i < n_lead; i++)
            enqueue(1'b1, 16'($urandom), 1'b0, 1'b0);
        for (int i = 0; i < n_sync; i++)
            enqueue(1'b0, 16'($urandom), 1'b0, 1'b0);
        for (int b = 0; b < n_bits; b++) begin
            one   = $urandom_range(0, 1);
            clean = $urandom_range(0, 59) != 0;
            enqueue(1'b1, near_width(one ? pr.one_high : pr.zero_high, pr.unit, clean),
                    1'b0, 1'b0);
            enqueue(1'b0, near_width(one ? pr.one_low : pr.zero_low, pr.unit, 1'b1),
                    tail == 0 && b == n_bits - 1, 1'b0);
        end
        if (tail != 0)
            enqueue(tail == 1, 16'($urandom), 1'b1, 1'b0);
    endfunction

    function automatic void queue_captures(input int budget);
        phase_items = 0;
        while (phase_items < budget)
            queue_capture($urandom_range(0, 4) != 0);
    endfunction

    function automatic logic [25:0] rand_proto();
        logic [31:0] raw;
        t_proto      pr;
        raw = $urandom;
        pr  = raw[25:0];
        if (pr.unit == 0)
            pr.unit = 10'd1;
        return pr;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes (only while the decoder is idle)
    // ------------------------------------------------------------------

    // Hold valid high until the transfer; leave it high so back-to-back
    // writes never drop and raise it in the same step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [25:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        if (idx < CFG_SLOTS)
            proto_reg[idx[1:0]] = val;
        else if (idx == REG_COUNT)
            slots_used_reg = val[2:0];
    endtask

    task automatic program_slots(input logic [25:0] s0, input logic [25:0] s1,
                                 input logic [25:0] s2, input logic [25:0] s3,
                                 input logic [2:0] count);
        // stray indexes first: none of them may disturb the real registers
        write_reg(REG_STRAY_A, rand_proto());
        write_reg(REG_STRAY_B, '1);
        write_reg(REG_SLOT0, s0);
        write_reg(REG_SLOT1, s1);
        write_reg(REG_SLOT2, s2);
        write_reg(REG_SLOT3, s3);
        write_reg(REG_COUNT, {23'd0, count});
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait for every queued pulse to go in and every code to come out, then
    // let the pipeline run empty.
    task automatic wait_drained();
        while (pulse_backlog.size() != 0 || pulse_ch.valid || expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Pulse sender: bursts of random length separated by random gaps.
    // Predict on every pulse transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pulse_ch.valid <= 1'b0;
        end else begin
            if (pulse_ch.valid && pulse_ch.ready) begin
                if (decode_pulse(on_wire.p, outcome))
                    expected_codes.push_back(on_wire.no_code ? NO_CODE : outcome);
            end
            if (!pulse_ch.valid || pulse_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pulse_ch.valid <= 1'b0;
                end else if (sender_hold || pulse_backlog.size() == 0) begin
                    pulse_ch.valid <= 1'b0;
                end else begin
                    on_wire = pulse_backlog.pop_front();
                    pulse_ch.valid          <= 1'b1;
                    pulse_ch.pulse_level    <= on_wire.p.level;
                    pulse_ch.pulse_duration <= on_wire.p.duration;
                    pulse_ch.last_pulse     <= on_wire.p.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // a quarter of the bursts run straight into the next
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Code receiver: stalls in modes of its own, plus one long hold on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_ch.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
            code_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            code_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                rx_pattern = 8'($urandom);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN: begin
                    code_ch.ready <= 1'b1;
                end
                RX_SPARSE: begin
                    code_ch.ready <= $urandom_range(0, 3) != 0;
                end
                RX_PATTERN: begin
                    code_ch.ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
                default: begin
                    code_ch.ready <= 1'($urandom);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Code checker: each transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (expected_codes.size() == 0) begin
                $error("code transfer with no capture closed");
                error_count++;
            end else begin
                want = expected_codes.pop_front();
                if (code_ch.code_valid !== want.code_valid) begin
                    $error("code_valid: expected %0d, got %0d",
                           want.code_valid, code_ch.code_valid);
                    error_count++;
                end
                if (code_ch.decoded_code !== want.decoded_code) begin
                    $error("decoded_code: expected %h, got %h",
                           want.decoded_code, code_ch.decoded_code);
                    error_count++;
                end
                if (code_ch.protocol_slot !== want.protocol_slot) begin
                    $error("protocol_slot: expected %0d, got %0d",
                           want.protocol_slot, code_ch.protocol_slot);
                    error_count++;
                end
                if (code_ch.bit_count !== want.bit_count) begin
                    $error("bit_count: expected %0d, got %0d",
                           want.bit_count, code_ch.bit_count);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_proto odd_a;
        t_proto odd_b;

        // Drive every input to a known value before the first edge.
        pulse_ch.valid          = 1'b0;
        pulse_ch.pulse_level    = 1'b0;
        pulse_ch.pulse_duration = '0;
        pulse_ch.last_pulse     = 1'b0;
        code_ch.ready           = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_SLOT0;
        cfg_ch.data             = '0;
        error_count   = 0;
        burst_left    = 1;
        gap_left      = 0;
        sender_hold   = 1'b0;
        long_hold_req = 1'b0;
        hold_left     = 0;
        mode_left     = 0;
        rx_mode       = RX_OPEN;
        rx_pattern    = '1;

        // Mirror the reset values of the registers.
        proto_reg[0]   = SLOT0_RESET;
        proto_reg[1]   = '0;
        proto_reg[2]   = '0;
        proto_reg[3]   = '0;
        slots_used_reg = COUNT_RESET;
        clear_capture();

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset configuration.
        for (int r = 0; r < $size(DIRECTED); r++)
            repeat (DIRECTED[r].reps)
                enqueue(DIRECTED[r].level, DIRECTED[r].duration, DIRECTED[r].last,
                        DIRECTED[r].no_code);
        wait_drained();

        // Reset values written back explicitly; slots one to three all zero.
        program_slots(SLOT0_RESET, '0, '0, '0, COUNT_RESET);
        queue_captures(200);
        wait_drained();

        // All four slots random and in use. Hold the receiver off for a long
        // stretch while pulses keep coming, so the input backs up.
        program_slots(rand_proto(), rand_proto(), rand_proto(), rand_proto(), 3'd4);
        long_hold_req = 1'b1;
        queue_captures(220);
        wait_drained();

        // Zero unit in slot zero (never matches), identical one and zero
        // patterns in slot one (always a one), count above the slot number.
        odd_a = rand_proto();
        odd_a.unit = '0;
        odd_b = rand_proto();
        odd_b.zero_high = odd_b.one_high;
        odd_b.zero_low  = odd_b.one_low;
        program_slots(odd_a, odd_b, rand_proto(), rand_proto(), 3'd7);
        queue_captures(200);
        wait_drained();

        // Count of zero: slots still decode, nothing is ever reported.
        program_slots('0, rand_proto(), rand_proto(), rand_proto(), 3'd0);
        queue_captures(150);
        wait_drained();

        // Every protocol field at its maximum.
        program_slots('1, '1, '1, '1, 3'd2);
        queue_captures(200);
        wait_drained();

        // Random setting; halfway through, stop sending until every
        // outstanding code is back, then resume.
        program_slots(rand_proto(), rand_proto(), rand_proto(), rand_proto(),
                      3'($urandom_range(1, 4)));
        queue_captures(280);
        while (pulse_backlog.size() > 140)
            @(posedge i_clk);
        sender_hold = 1'b1;
        while (pulse_ch.valid || expected_codes.size() != 0)
            @(posedge i_clk);
        sender_hold = 1'b0;
        wait_drained();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
